[hdl/b64_pkg.sv]
// ----------------------------------------------------------------------------
// b64_pkg: shared types and helpers for the base64 stream encoder
// Group record passed from the byte gatherer to the character emitter, and
// the sextet-to-ASCII mapping of the standard alphabet.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned GroupW = 3 * ByteW;
  localparam int unsigned CntW   = 3;

  localparam logic [CharW-1:0] PadChar = 7'h3d;  // '='

  // One gathered group: three bytes (missing ones zero) and the number of
  // real sextets, 2 to 4. The rest of the four characters are padding.
  typedef struct packed {
    logic [GroupW-1:0] bytes;
    logic [CntW-1:0]   n_sext;
  } grp_t;

  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] s);
    logic [CharW-1:0] s7;
    s7 = {1'b0, s};
    if (s < 6'd26) begin
      sextet_char = s7 + 7'd65;           // 'A'..'Z'
    end else if (s < 6'd52) begin
      sextet_char = s7 + 7'd71;           // 'a'..'z'
    end else if (s < 6'd62) begin
      sextet_char = s7 - 7'd4;            // '0'..'9'
    end else if (s == 6'd62) begin
      sextet_char = 7'h2b;                // '+'
    end else begin
      sextet_char = 7'h2f;                // '/'
    end
  endfunction

endpackage

[hdl/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder: streaming base64 encoder, standard alphabet
// Bytes in, ASCII characters out; a group of three bytes, or a final
// partial group padded with '=', yields four characters.
// ----------------------------------------------------------------------------
//  channel | handshake     | payload
//  --------+---------------+-----------------------------------
//  bytes   | push / full   | data_byte_i[7:0], final_byte_i
//  chars   | pop / empty   | out_char_o[6:0], run_end_o
//
//  A byte is taken each cycle while the group queue has room; the emitter
//  sends one character per cycle while the output is popped, so sustained
//  input is limited to three bytes per four characters sent.
//  The byte that closes a group passes the group queue, the emitter's group register and the output register.
//  Reset clears the phase, held bytes, queue pointers and output valid flag.
//  Output stalls back up into the two-entry group queue, then into full.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char_o,
  output logic       run_end_o
);
  import b64_pkg::*;

  logic grp_wr, grp_full, grp_take, grp_empty;
  grp_t grp_in, grp_out;

  b64_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .grp_valid_o  (grp_wr),
    .grp_o        (grp_in),
    .grp_full_i   (grp_full)
  );

  b64_gq u_gq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (grp_wr),
    .wr_data_i (grp_in),
    .full_o    (grp_full),
    .rd_en_i   (grp_take),
    .rd_data_o (grp_out),
    .empty_o   (grp_empty)
  );

  b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp_out),
    .grp_empty_i (grp_empty),
    .grp_take_o  (grp_take),
    .empty       (empty),
    .pop         (pop),
    .out_char_o  (out_char_o),
    .run_end_o   (run_end_o)
  );

endmodule

[hdl/b64_front.sv]
// ----------------------------------------------------------------------------
// b64_front: byte gatherer
// Accepts one byte per beat, tracks the group phase and held bytes, and
// hands a finished or final group to the group queue.
// ----------------------------------------------------------------------------
module b64_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               final_byte_i,
  output logic               grp_valid_o,
  output b64_pkg::grp_t      grp_o,
  input  logic               grp_full_i
);
  import b64_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] held_q, held_d;
  logic        acc;

  assign full = grp_full_i;
  assign acc  = push & ~grp_full_i;

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    grp_valid_o = 1'b0;
    grp_o       = '0;
    case (phase_q)
      2'd1: begin
        if (final_byte_i) begin
          grp_valid_o = acc;
          grp_o.bytes  = {held_q[15:8], data_byte_i, 8'h00};
          grp_o.n_sext = 3'd3;
          phase_d      = 2'd0;
          held_d       = '0;
        end else begin
          held_d  = {held_q[15:8], data_byte_i};
          phase_d = 2'd2;
        end
      end
      2'd2: begin
        grp_valid_o  = acc;
        grp_o.bytes  = {held_q, data_byte_i};
        grp_o.n_sext = 3'd4;
        phase_d      = 2'd0;
        held_d       = '0;
      end
      default: begin
        // phase three cannot arise; it behaves as phase zero
        if (final_byte_i) begin
          grp_valid_o  = acc;
          grp_o.bytes  = {data_byte_i, 16'h0000};
          grp_o.n_sext = 3'd2;
          phase_d      = 2'd0;
          held_d       = '0;
        end else begin
          held_d  = {data_byte_i, 8'h00};
          phase_d = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

[hdl/b64_gq.sv]
// ----------------------------------------------------------------------------
// b64_gq: group queue
// Two-entry queue of gathered groups between the gatherer and the emitter.
// ----------------------------------------------------------------------------
module b64_gq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  b64_pkg::grp_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output b64_pkg::grp_t rd_data_o,
  output logic          empty_o
);
  import b64_pkg::*;

  grp_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= wr_data_i;
    end
  end

endmodule

[hdl/b64_back.sv]
// ----------------------------------------------------------------------------
// b64_back: character emitter
// Takes one group at a time and sends its four characters, one per beat,
// through an output register; the next group is taken on the last beat.
// ----------------------------------------------------------------------------
module b64_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  b64_pkg::grp_t grp_i,
  input  logic          grp_empty_i,
  output logic          grp_take_o,
  output logic          empty,
  input  logic          pop,
  output logic [6:0]    out_char_o,
  output logic          run_end_o
);
  import b64_pkg::*;

  grp_t       cur_q;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       ovld_q, ovld_d;
  logic [6:0] char_q;
  logic       end_q;
  logic       slot_free, emit, last;
  logic [5:0] sext;
  logic [6:0] char_d;

  assign slot_free  = ~ovld_q | pop;
  assign emit       = busy_q & slot_free;
  assign last       = (idx_q == 2'd3);
  assign grp_take_o = ~grp_empty_i & (~busy_q | (emit & last));

  always_comb begin
    case (idx_q)
      2'd0:    sext = cur_q.bytes[23:18];
      2'd1:    sext = cur_q.bytes[17:12];
      2'd2:    sext = cur_q.bytes[11:6];
      default: sext = cur_q.bytes[5:0];
    endcase
    char_d = ({1'b0, idx_q} < cur_q.n_sext) ? sextet_char(sext) : PadChar;
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (grp_take_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (emit) begin
      idx_d = idx_q + 2'd1;
      if (last) busy_d = 1'b0;
    end
    if (emit) begin
      ovld_d = 1'b1;
    end else if (pop) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_take_o) cur_q <= grp_i;
    if (emit) begin
      char_q <= char_d;
      end_q  <= last;
    end
  end

  assign empty      = ~ovld_q;
  assign out_char_o = char_q;
  assign run_end_o  = end_q;

endmodule

[tb/tb_base64_stream_encoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder: self-checking bench for the base64 stream encoder
// Byte beats are queued by a stimulus process and driven with random gaps.
// A built-in encoder model predicts each character beat. The monitor pops
// with random stalls, including one long hold-off that backs the DUT up.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;

  localparam int unsigned CW        = b64_pkg::CharW;
  localparam int          MAX_WAIT  = 17;
  localparam int          HOLD_LEN  = 400;
  localparam int          HOLD_AT   = 60;
  localparam int          RAND_ITEMS = 350;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } byte_beat_t;

  typedef struct {
    logic [CW-1:0] ch;
    logic          last;
  } char_beat_t;

  logic          clk_i        = 1'b0;
  logic          rst_ni       = 1'b0;
  logic          push         = 1'b0;
  logic          full;
  logic [7:0]    data_byte_i  = 8'h00;
  logic          final_byte_i = 1'b0;
  logic          empty;
  logic          pop          = 1'b0;
  logic [CW-1:0] out_char_o;
  logic          run_end_o;

  byte_beat_t pend_q[$];
  char_beat_t char_q[$];

  // encoder model state
  logic [1:0]  grp_phase;
  logic [15:0] grp_held;

  string b64_alpha = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz",
                      "0123456789+/"};

  int  n_errors  = 0;
  int  n_chars   = 0;
  int  cycles    = 0;
  int  send_gap  = 0;
  int  pop_gap   = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;
  bit  tx_fast   = 1'b0;
  bit  rx_fast   = 1'b0;
  logic       took_byte;
  byte_beat_t nxt_beat;
  char_beat_t want;

  base64_stream_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char_o),
    .run_end_o    (run_end_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [CW-1:0] alpha_char(logic [5:0] s);
    byte c;
    c = b64_alpha[s];
    return c[CW-1:0];
  endfunction

  function automatic int pick_wait(bit fast);
    return fast ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // four characters: 'count' sextets of a,b,c then '=' padding
  task automatic queue_group(logic [7:0] a, logic [7:0] b, logic [7:0] c, int count);
    logic [5:0] s[4];
    char_beat_t cb;
    s[0] = a[7:2];
    s[1] = {a[1:0], b[7:4]};
    s[2] = {b[3:0], c[7:6]};
    s[3] = c[5:0];
    for (int k = 0; k < 4; k++) begin
      cb.ch   = (k < count) ? alpha_char(s[k]) : b64_pkg::PadChar;
      cb.last = (k == 3);
      char_q.push_back(cb);
    end
  endtask

  task automatic encode_byte(logic [7:0] d, logic fin);
    case (grp_phase)
      2'd1: begin
        if (fin) begin
          queue_group(grp_held[15:8], d, 8'h00, 3);
          grp_phase = 2'd0;
          grp_held  = 16'h0000;
        end else begin
          grp_held[7:0] = d;
          grp_phase     = 2'd2;
        end
      end
      2'd2: begin
        queue_group(grp_held[15:8], grp_held[7:0], d, 4);
        grp_phase = 2'd0;
        grp_held  = 16'h0000;
      end
      default: begin
        if (fin) begin
          queue_group(d, 8'h00, 8'h00, 2);
          grp_phase = 2'd0;
          grp_held  = 16'h0000;
        end else begin
          grp_held  = {d, 8'h00};
          grp_phase = 2'd1;
        end
      end
    endcase
  endtask

  task automatic add_beat(logic [7:0] d, logic fin);
    byte_beat_t bb;
    bb.data = d;
    bb.fin  = fin;
    pend_q.push_back(bb);
  endtask

  // driver: one byte beat at a time, random gap after each accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      took_byte = push && !full;
      if (took_byte) begin
        encode_byte(data_byte_i, final_byte_i);
        if ($urandom_range(0, 29) == 0) tx_fast = !tx_fast;
        send_gap = pick_wait(tx_fast);
      end
      if (took_byte || !push) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pend_q.size() != 0) begin
          nxt_beat = pend_q.pop_front();
          data_byte_i  <= nxt_beat.data;
          final_byte_i <= nxt_beat.fin;
          push         <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each popped character beat against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_chars++;
        if (char_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: unexpected char beat %h last %b", out_char_o, run_end_o);
        end else begin
          want = char_q.pop_front();
          if (out_char_o !== want.ch || run_end_o !== want.last) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: char exp %h got %h, last exp %b got %b",
                       want.ch, out_char_o, want.last, run_end_o);
          end
        end
        if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
        pop_gap = pick_wait(rx_fast);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (n_chars >= HOLD_AT && !held_once) begin
        // long stall so the input side backs up into full
        held_once = 1'b1;
        hold_left = HOLD_LEN;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_base64_stream_encoder: FAIL");
      $finish;
    end
  end

  initial begin
    int n_items;
    int len;
    int r;
    logic [7:0] d;
    grp_phase = 2'd0;
    grp_held  = 16'h0000;

    // directed: one-byte, two-byte and three-byte finals, alphabet extremes
    add_beat(8'h00, 1'b1);                                           // "AA=="
    add_beat(8'hff, 1'b1);                                           // "/w=="
    add_beat(8'hff, 1'b0); add_beat(8'hff, 1'b1);                    // "//8="
    add_beat(8'h00, 1'b0); add_beat(8'h00, 1'b0); add_beat(8'h00, 1'b1);
    add_beat(8'hff, 1'b0); add_beat(8'hff, 1'b0); add_beat(8'hff, 1'b0);
    add_beat(8'hfb, 1'b0); add_beat(8'hef, 1'b0); add_beat(8'hbe, 1'b1);
    add_beat(8'h4d, 1'b0); add_beat(8'h61, 1'b0); add_beat(8'h6e, 1'b0);
    add_beat(8'haa, 1'b1);                                           // group then "=="
    add_beat(8'h55, 1'b0); add_beat(8'haa, 1'b1);
    add_beat(8'h80, 1'b0); add_beat(8'h01, 1'b0); add_beat(8'h7f, 1'b1);
    add_beat(8'h03, 1'b0); add_beat(8'hfc, 1'b1);

    // random messages, mostly short, some long
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(1, 6);
      else if (r < 9) len = $urandom_range(7, 20);
      else len = $urandom_range(21, 45);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 15);
        if (r == 0) d = 8'h00;
        else if (r == 1) d = 8'hff;
        else d = 8'($urandom_range(0, 255));
        add_beat(d, i == len - 1);
      end
      n_items += len;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample between edges so the driver's updates of this cycle are settled
    do @(negedge clk_i);
    while (pend_q.size() != 0 || push || char_q.size() != 0);
    repeat (30) @(posedge clk_i);

    if (char_q.size() != 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch: %0d char beats never arrived", char_q.size());
    end
    if (n_errors == 0) begin
      $display("tb_base64_stream_encoder: PASS");
    end else begin
      $display("tb_base64_stream_encoder: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/b64_pkg.sv
hdl/b64_front.sv
hdl/b64_gq.sv
hdl/b64_back.sv
hdl/base64_stream_encoder.sv
tb/tb_base64_stream_encoder.sv
